@@ design/sati_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the steering arbiter with table interpolation.
// No dependencies; imported by sati_div, the top module and the testbench.
package sati_pkg;

  localparam int TABLE_POINTS_DEF = 16;

  // Port field widths
  localparam int CMD_W      = 2;
  localparam int DUTY_W     = 16;
  localparam int TELE_W     = 16;
  localparam int RAD_W      = 24;
  localparam int IDX_W      = 4;
  localparam int VAL_W      = 17;
  localparam int SRC_W      = 2;
  localparam int PTS_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register reset values
  localparam logic [DUTY_W-1:0] FULL_LEFT_RST  = 16'd3800;
  localparam logic [DUTY_W-1:0] CENTRE_RST     = 16'd5100;
  localparam logic [DUTY_W-1:0] FULL_RIGHT_RST = 16'd6700;
  localparam logic [PTS_W-1:0]  PTS_RST        = 5'd16;

  // Gamepad request is Q1.14; the turn radius carries 8 more fraction bits than axis entries
  localparam logic signed [TELE_W:0] TELE_HALF = 17'sd8192;
  localparam logic signed [TELE_W:0] TELE_EPS  = 17'sd16;
  localparam int TELE_FRAC = 14;
  localparam int AXIS_FRAC = 8;

  // Datapath widths
  localparam int MUL_A_W = 26;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int DEN_W   = DUTY_W + 1 + AXIS_FRAC;
  localparam int QUO_W   = DUTY_W;
  localparam int NUM_W   = DEN_W + QUO_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_COMPUTE    = 2'd0,
    CMD_LOAD_AXIS  = 2'd1,
    CMD_LOAD_LEFT  = 2'd2,
    CMD_LOAD_RIGHT = 2'd3
  } cmd_t;

  typedef enum logic [SRC_W-1:0] {
    SRC_DEADMAN = 2'd0,
    SRC_TELE    = 2'd1,
    SRC_AUTO    = 2'd2,
    SRC_CENTER  = 2'd3
  } src_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FULL_LEFT  = 2'd0,
    CFG_CENTRE     = 2'd1,
    CFG_FULL_RIGHT = 2'd2,
    CFG_POINTS     = 2'd3
  } cfg_idx_t;

endpackage

@@ design/sati_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sati_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/sati_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the interpolation step.
// Depends on sati_pkg; the quotient is known to fit QUO_W bits.
module sati_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [sati_pkg::NUM_W-1:0] dividend,
  input  logic [sati_pkg::DEN_W-1:0] divisor,
  output logic                      done,
  output logic [sati_pkg::QUO_W-1:0] quotient
);
  import sati_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] low_r, low_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] div_r, div_nxt;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, low_r[QUO_W-1]};
  assign fits  = (trial >= {1'b0, div_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start) begin
      // high part is already below the divisor since the quotient fits QUO_W bits
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = dividend[NUM_W-1:QUO_W];
      low_nxt  = dividend[QUO_W-1:0];
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? DEN_W'(trial - {1'b0, div_r}) : DEN_W'(trial);
      low_nxt = {low_r[QUO_W-2:0], 1'b0};
      quo_nxt = {quo_r[QUO_W-2:0], fits};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(QUO_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ design/steering_arbiter_table_interp.sv @@
`timescale 1ns / 1ps
// Servo steering arbiter: deadman, gamepad scaling and a piecewise-linear
// turn-radius table. Depends on sati_pkg, sati_ram and sati_div.
//
// Use: an input request with cmd load-axis/left/right writes one table point
// and gives no result. A compute request gives one result (servo_duty and
// source) on the out_ channel. Configuration writes go through the cfg_
// channel, which is always ready; write it only while the block is idle.
// Path of a compute request from acceptance to out_valid:
//   deadman off or default center: straight to the output register
//   gamepad: one multiply, one add, one round and clamp, then output
//   autonomous: a registered RAM read, then a compare, per axis point
//   walked, then two multiplies and the 16-step serial divider; a latched
//   end point goes straight to the output register.
// One request is in work at a time: in_stall stays high from acceptance until
// the result moves into the output register. The output register holds a
// result while out_stall is high; a load request may be accepted meanwhile,
// and the next compute finishes only when the register is free.
// Reset restores the configuration registers and empties the output; the
// table contents are undefined until loaded.
module steering_arbiter_table_interp #(
  parameter int TABLE_POINTS = sati_pkg::TABLE_POINTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [sati_pkg::CMD_W-1:0]      in_cmd,
  input  logic                           in_human_in_loop,
  input  logic signed [sati_pkg::TELE_W-1:0] in_tele_request,
  input  logic signed [sati_pkg::RAD_W-1:0]  in_av_turn_radius,
  input  logic [sati_pkg::IDX_W-1:0]      in_entry_index,
  input  logic signed [sati_pkg::VAL_W-1:0]  in_entry_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sati_pkg::DUTY_W-1:0]     out_servo_duty,
  output logic [sati_pkg::SRC_W-1:0]      out_source,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sati_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sati_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sati_pkg::*;

  localparam int AW = $clog2(TABLE_POINTS);
  localparam int CW = $clog2(TABLE_POINTS + 1);
  localparam logic signed [ACC_W-1:0] TELE_RND = ACC_W'((1 << TELE_FRAC) - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TELE_MUL,
    S_TELE_SUM,
    S_TELE_FIN,
    S_RD,
    S_CMP,
    S_MUL_A,
    S_MUL_B,
    S_SUM,
    S_DIV,
    S_DONE
  } state_t;

  // Configuration registers
  logic [DUTY_W-1:0] full_left_r, centre_r, full_right_r;
  logic [PTS_W-1:0]  pts_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_left_r  <= FULL_LEFT_RST;
      centre_r     <= CENTRE_RST;
      full_right_r <= FULL_RIGHT_RST;
      pts_r        <= PTS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FULL_LEFT:  full_left_r  <= cfg_data;
        CFG_CENTRE:     centre_r     <= cfg_data;
        CFG_FULL_RIGHT: full_right_r <= cfg_data;
        CFG_POINTS:     pts_r        <= cfg_data[PTS_W-1:0];
        default:        ;
      endcase
    end
  end

  // Clamp the point count to 1..TABLE_POINTS
  logic [CW-1:0] n_pts;
  logic [AW-1:0] last_idx;

  always_comb begin
    if (pts_r == '0) begin
      n_pts = CW'(1);
    end else if (32'(pts_r) > TABLE_POINTS) begin
      n_pts = CW'(TABLE_POINTS);
    end else begin
      n_pts = CW'(pts_r);
    end
  end

  assign last_idx = AW'(n_pts - CW'(1));

  // State and datapath registers
  state_t                   state_r, state_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [DUTY_W-1:0]        out_duty_r, out_duty_nxt;
  src_t                     out_src_r, out_src_nxt;
  logic [DUTY_W-1:0]        duty_r, duty_nxt;
  src_t                     src_r, src_nxt;
  logic signed [TELE_W-1:0] t_r, t_nxt;
  logic signed [RAD_W-1:0]  r_r, r_nxt;
  logic                     left_sel_r, left_sel_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic [DUTY_W-1:0]        xl_r, xl_nxt;
  logic [DUTY_W-1:0]        yl_r, yl_nxt;
  logic [DUTY_W-1:0]        yr_r, yr_nxt;
  logic signed [DEN_W-1:0]  den_r, den_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [PROD_W-1:0] prod_r;

  // Loads write the tables straight from the input request
  logic                     in_acc;
  logic                     load_ok;
  logic [IDX_W+AW-1:0]      idx_wide;
  logic [AW-1:0]            waddr;
  logic [DUTY_W-1:0]        axis_rd, left_rd, right_rd, tab_rd;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign load_ok  = in_acc && (in_cmd != CMD_COMPUTE) && (32'(in_entry_index) < TABLE_POINTS);
  assign idx_wide = (IDX_W + AW)'(in_entry_index);
  assign waddr    = idx_wide[AW-1:0];

  sati_ram #(.WIDTH(DUTY_W), .DEPTH(TABLE_POINTS)) u_axis_ram (
    .clk   (clk),
    .we    (load_ok && (in_cmd == CMD_LOAD_AXIS)),
    .waddr (waddr),
    .wdata (in_entry_value[DUTY_W-1:0]),
    .raddr (idx_r),
    .rdata (axis_rd)
  );

  sati_ram #(.WIDTH(DUTY_W), .DEPTH(TABLE_POINTS)) u_left_ram (
    .clk   (clk),
    .we    (load_ok && (in_cmd == CMD_LOAD_LEFT)),
    .waddr (waddr),
    .wdata (in_entry_value[DUTY_W-1:0]),
    .raddr (idx_r),
    .rdata (left_rd)
  );

  sati_ram #(.WIDTH(DUTY_W), .DEPTH(TABLE_POINTS)) u_right_ram (
    .clk   (clk),
    .we    (load_ok && (in_cmd == CMD_LOAD_RIGHT)),
    .waddr (waddr),
    .wdata (in_entry_value[DUTY_W-1:0]),
    .raddr (idx_r),
    .rdata (right_rd)
  );

  assign tab_rd = left_sel_r ? left_rd : right_rd;

  // Shared multiplier, product registered every cycle
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_B_W-1:0] tele_scale;
  logic signed [DEN_W-1:0]   r_off;

  assign tele_scale = (t_r > 0) ?
                      $signed({1'b0, full_left_r}) - $signed({1'b0, centre_r}) :
                      $signed({1'b0, centre_r}) - $signed({1'b0, full_right_r});
  assign r_off = $signed({r_r[RAD_W-1], r_r}) -
                 $signed({xl_r[DUTY_W-1], xl_r, {AXIS_FRAC{1'b0}}});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_TELE_MUL: begin
        mul_a = MUL_A_W'(tele_scale);
        mul_b = MUL_B_W'(t_r);
      end
      S_MUL_A: begin
        mul_a = MUL_A_W'(den_r);
        mul_b = $signed({1'b0, yl_r});
      end
      S_MUL_B: begin
        mul_a = MUL_A_W'(r_off);
        mul_b = $signed({1'b0, yr_r}) - $signed({1'b0, yl_r});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Divider
  logic                    div_start;
  logic                    div_done;
  logic [QUO_W-1:0]        div_quo;
  logic signed [ACC_W-1:0] interp_num;

  assign interp_num = acc_r + ACC_W'(prod_r);
  assign div_start  = (state_r == S_SUM);

  sati_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (interp_num[NUM_W-1:0]),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Decode of a compute request, and helper terms for the sequencer
  logic signed [TELE_W:0]   tele_dev;
  logic signed [RAD_W-1:0]  axis_pt;
  logic signed [DUTY_W:0]   dx;
  logic                     hit;
  logic signed [ACC_W-1:0]  tele_adj;
  logic signed [ACC_W-1:0]  tele_sh;

  assign tele_dev = $signed({in_tele_request[TELE_W-1], in_tele_request}) - TELE_HALF;
  assign axis_pt  = $signed({axis_rd, {AXIS_FRAC{1'b0}}});
  assign dx       = $signed({axis_rd[DUTY_W-1], axis_rd}) - $signed({xl_r[DUTY_W-1], xl_r});
  assign hit      = (idx_r == '0) ? (r_r <= axis_pt) : (r_r < axis_pt);
  // truncate toward zero
  assign tele_adj = acc_r[ACC_W-1] ? acc_r + TELE_RND : acc_r;
  assign tele_sh  = tele_adj >>> TELE_FRAC;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_duty_nxt  = out_duty_r;
    out_src_nxt   = out_src_r;
    duty_nxt      = duty_r;
    src_nxt       = src_r;
    t_nxt         = t_r;
    r_nxt         = r_r;
    left_sel_nxt  = left_sel_r;
    idx_nxt       = idx_r;
    xl_nxt        = xl_r;
    yl_nxt        = yl_r;
    yr_nxt        = yr_r;
    den_nxt       = den_r;
    acc_nxt       = acc_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_cmd == CMD_COMPUTE)) begin
          t_nxt        = in_tele_request;
          r_nxt        = in_av_turn_radius;
          left_sel_nxt = !in_av_turn_radius[RAD_W-1];
          idx_nxt      = '0;
          duty_nxt     = centre_r;
          if (!in_human_in_loop) begin
            src_nxt   = SRC_DEADMAN;
            state_nxt = S_DONE;
          end else if ((tele_dev > TELE_EPS) || (tele_dev < -TELE_EPS)) begin
            src_nxt   = SRC_TELE;
            state_nxt = S_TELE_MUL;
          end else if (in_av_turn_radius != '0) begin
            src_nxt   = SRC_AUTO;
            state_nxt = S_RD;
          end else begin
            src_nxt   = SRC_CENTER;
            state_nxt = S_DONE;
          end
        end
      end
      S_TELE_MUL: begin
        state_nxt = S_TELE_SUM;
      end
      S_TELE_SUM: begin
        acc_nxt   = $signed(ACC_W'({centre_r, {TELE_FRAC{1'b0}}})) + ACC_W'(prod_r);
        state_nxt = S_TELE_FIN;
      end
      S_TELE_FIN: begin
        if (tele_sh < 0) begin
          duty_nxt = '0;
        end else if (tele_sh > ACC_W'(16'hFFFF)) begin
          duty_nxt = '1;
        end else begin
          duty_nxt = tele_sh[DUTY_W-1:0];
        end
        state_nxt = S_DONE;
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (hit && (idx_r == '0)) begin
          duty_nxt  = tab_rd;
          state_nxt = S_DONE;
        end else if (hit) begin
          // a non-increasing segment latches its left point
          if (dx[DUTY_W] || (dx == '0)) begin
            duty_nxt  = yl_r;
            state_nxt = S_DONE;
          end else begin
            den_nxt   = $signed({dx, {AXIS_FRAC{1'b0}}});
            yr_nxt    = tab_rd;
            state_nxt = S_MUL_A;
          end
        end else if (idx_r == last_idx) begin
          duty_nxt  = tab_rd;
          state_nxt = S_DONE;
        end else begin
          xl_nxt    = axis_rd;
          yl_nxt    = tab_rd;
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_RD;
        end
      end
      S_MUL_A: begin
        state_nxt = S_MUL_B;
      end
      S_MUL_B: begin
        acc_nxt   = ACC_W'(prod_r);
        state_nxt = S_SUM;
      end
      S_SUM: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          duty_nxt  = div_quo;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_duty_nxt  = duty_r;
          out_src_nxt   = src_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_duty_r <= out_duty_nxt;
    out_src_r  <= out_src_nxt;
    duty_r     <= duty_nxt;
    src_r      <= src_nxt;
    t_r        <= t_nxt;
    r_r        <= r_nxt;
    left_sel_r <= left_sel_nxt;
    idx_r      <= idx_nxt;
    xl_r       <= xl_nxt;
    yl_r       <= yl_nxt;
    yr_r       <= yr_nxt;
    den_r      <= den_nxt;
    acc_r      <= acc_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_servo_duty = out_duty_r;
  assign out_source     = out_src_r;

endmodule

@@ tb/steering_arbiter_table_interp_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for steering_arbiter_table_interp: table loads, arbitration
// and interpolation checked against a duty predictor under random gaps and stalls.
// Depends on sati_pkg and the steering_arbiter_table_interp RTL.
module steering_arbiter_table_interp_tb;
  import sati_pkg::*;

  localparam int POINTS = TABLE_POINTS_DEF;
  localparam int SETTLE_CYCLES = 2 * POINTS + 23 + 10;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam longint AXIS_SCALE = longint'(1) << AXIS_FRAC;
  localparam longint TELE_ONE = longint'(1) << TELE_FRAC;
  localparam int RADIUS_MIN = -(1 << (RAD_W - 1));
  localparam int RADIUS_MAX = (1 << (RAD_W - 1)) - 1;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    src_t              source;
  } steer_result_t;

  // Keeps its own copy of the registers and tables and predicts each result.
  class duty_scoreboard;
    logic [DUTY_W-1:0]  full_left;
    logic [DUTY_W-1:0]  centre;
    logic [DUTY_W-1:0]  full_right;
    logic [PTS_W-1:0]   points;
    logic signed [15:0] axis_pts [POINTS];
    logic [DUTY_W-1:0]  left_duty [POINTS];
    logic [DUTY_W-1:0]  right_duty [POINTS];
    steer_result_t      pending_duties [$];
    int                 errors;

    function new();
      errors = 0;
      full_left = FULL_LEFT_RST;
      centre = CENTRE_RST;
      full_right = FULL_RIGHT_RST;
      points = PTS_RST;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_FULL_LEFT:  full_left = data;
        CFG_CENTRE:     centre = data;
        CFG_FULL_RIGHT: full_right = data;
        default:        points = data[PTS_W-1:0];
      endcase
    endfunction

    function int used_points();
      if (points < 1) return 1;
      if (points > POINTS) return POINTS;
      return int'(points);
    endfunction

    function logic [DUTY_W-1:0] clamp_duty(longint v);
      if (v < 0) return '0;
      if (v > 65535) return '1;
      return v[DUTY_W-1:0];
    endfunction

    function logic [DUTY_W-1:0] tele_duty(longint t);
      longint c;
      longint scale;
      c = longint'(centre);
      if (t == 0) return centre;
      scale = (t > 0) ? longint'(full_left) - c : c - longint'(full_right);
      return clamp_duty((c * TELE_ONE + scale * t) / TELE_ONE);
    endfunction

    function longint duty_at(bit left_side, int i);
      return left_side ? longint'(left_duty[i]) : longint'(right_duty[i]);
    endfunction

    // Walk the axis to the first point above the radius, then interpolate.
    function logic [DUTY_W-1:0] radius_duty(bit left_side, longint r);
      int     n;
      int     i;
      longint xl;
      longint xr;
      longint yl;
      longint yr;
      longint den;
      n = used_points();
      if (r <= longint'(axis_pts[0]) * AXIS_SCALE) return clamp_duty(duty_at(left_side, 0));
      for (i = 1; i < n; i++) begin
        xr = longint'(axis_pts[i]) * AXIS_SCALE;
        if (r < xr) begin
          xl = longint'(axis_pts[i-1]) * AXIS_SCALE;
          yl = duty_at(left_side, i - 1);
          yr = duty_at(left_side, i);
          den = xr - xl;
          if (den <= 0) return clamp_duty(yl);
          return clamp_duty((yl * den + (r - xl) * (yr - yl)) / den);
        end
      end
      return clamp_duty(duty_at(left_side, n - 1));
    endfunction

    function void note_request(cmd_t cmd, logic hil, logic signed [TELE_W-1:0] tele,
                               logic signed [RAD_W-1:0] rad, logic [IDX_W-1:0] idx,
                               logic signed [VAL_W-1:0] val);
      steer_result_t res;
      longint        t;
      longint        r;
      longint        d;
      t = longint'(tele);
      r = longint'(rad);
      d = t - 8192;
      if (cmd == CMD_LOAD_AXIS) begin
        axis_pts[idx] = val[15:0];
      end else if (cmd == CMD_LOAD_LEFT) begin
        left_duty[idx] = val[15:0];
      end else if (cmd == CMD_LOAD_RIGHT) begin
        right_duty[idx] = val[15:0];
      end else begin
        if (!hil) begin
          res.duty = centre;
          res.source = SRC_DEADMAN;
        end else if (d > longint'(TELE_EPS) || d < -longint'(TELE_EPS)) begin
          res.duty = tele_duty(t);
          res.source = SRC_TELE;
        end else if (r != 0) begin
          res.duty = radius_duty(r > 0, r);
          res.source = SRC_AUTO;
        end else begin
          res.duty = centre;
          res.source = SRC_CENTER;
        end
        pending_duties.push_back(res);
      end
    endfunction

    function void check_result(logic [DUTY_W-1:0] duty, logic [SRC_W-1:0] source);
      steer_result_t exp_r;
      if (pending_duties.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, duty %0d source %0d", $time, duty, source);
        return;
      end
      exp_r = pending_duties.pop_front();
      if (duty !== exp_r.duty) begin
        errors++;
        $display("%0t: servo_duty mismatch, expected %0d, actual %0d",
                 $time, exp_r.duty, duty);
      end
      if (source !== exp_r.source) begin
        errors++;
        $display("%0t: source mismatch, expected %0d, actual %0d",
                 $time, exp_r.source, source);
      end
    endfunction

    function int outstanding();
      return pending_duties.size();
    endfunction

    function void close_out();
      if (pending_duties.size() != 0) begin
        errors++;
        $display("%0t: %0d expected results never arrived", $time, pending_duties.size());
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [CMD_W-1:0]          in_cmd;
  logic                      in_human_in_loop;
  logic signed [TELE_W-1:0]  in_tele_request;
  logic signed [RAD_W-1:0]   in_av_turn_radius;
  logic [IDX_W-1:0]          in_entry_index;
  logic signed [VAL_W-1:0]   in_entry_value;
  logic                      out_valid;
  logic                      out_stall;
  logic [DUTY_W-1:0]         out_servo_duty;
  logic [SRC_W-1:0]          out_source;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;

  duty_scoreboard sb;
  int gap_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  steering_arbiter_table_interp DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_human_in_loop  (in_human_in_loop),
    .in_tele_request   (in_tele_request),
    .in_av_turn_radius (in_av_turn_radius),
    .in_entry_index    (in_entry_index),
    .in_entry_value    (in_entry_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_servo_duty    (out_servo_duty),
    .out_source        (out_source),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_request(cmd_t'(in_cmd), in_human_in_loop, in_tele_request, in_av_turn_radius,
                      in_entry_index, in_entry_value);
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_servo_duty, out_source);
  end

  // Count cycles with no handshake on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(cmd_t cmd, logic hil, logic signed [TELE_W-1:0] tele,
                              logic signed [RAD_W-1:0] rad, logic [IDX_W-1:0] idx,
                              logic signed [VAL_W-1:0] val);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_human_in_loop <= hil;
    in_tele_request <= tele;
    in_av_turn_radius <= rad;
    in_entry_index <= idx;
    in_entry_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic int rand_tele();
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  function automatic int rand_value();
    return int'($urandom_range(0, 98303)) - 32768;
  endfunction

  task automatic load_entry(cmd_t cmd, int idx, int val);
    send_request(cmd, 1'($urandom_range(0, 1)), TELE_W'(rand_tele()), RAD_W'($urandom()),
                 IDX_W'(idx), VAL_W'(val));
  endtask

  task automatic compute(logic hil, int tele, int rad);
    send_request(CMD_COMPUTE, hil, TELE_W'(tele), RAD_W'(rad), IDX_W'($urandom()),
                 VAL_W'($urandom()));
  endtask

  // Hold the sender until every expected result is back, plus a settle time.
  task automatic drain(int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(int left, int mid, int right, int pts);
    write_reg(CFG_FULL_LEFT, CFG_DATA_W'(left));
    write_reg(CFG_CENTRE, CFG_DATA_W'(mid));
    write_reg(CFG_FULL_RIGHT, CFG_DATA_W'(right));
    write_reg(CFG_POINTS, CFG_DATA_W'(pts));
    cfg_valid <= 1'b0;
  endtask

  task automatic reload_tables(bit ordered);
    int pos;
    int step_max;
    int i;
    pos = int'($urandom_range(0, 40000)) - 32768;
    step_max = ($urandom_range(0, 1) == 1) ? 4000 : 300;
    for (i = 0; i < POINTS; i++) begin
      if (ordered) begin
        load_entry(CMD_LOAD_AXIS, i, pos);
        pos = pos + int'($urandom_range(1, step_max));
        if (pos > 32767) pos = 32767;
      end else begin
        load_entry(CMD_LOAD_AXIS, i, int'($urandom_range(0, 65535)) - 32768);
      end
    end
    for (i = 0; i < POINTS; i++) load_entry(CMD_LOAD_LEFT, i, rand_value());
    for (i = 0; i < POINTS; i++) load_entry(CMD_LOAD_RIGHT, i, rand_value());
  endtask

  // Radius somewhere across the used axis, a little past both ends.
  function automatic int span_radius();
    int     n;
    int     i;
    longint lo;
    longint hi;
    longint r;
    n = sb.used_points();
    lo = longint'(sb.axis_pts[0]);
    hi = lo;
    for (i = 1; i < n; i++) begin
      if (longint'(sb.axis_pts[i]) < lo) lo = longint'(sb.axis_pts[i]);
      if (longint'(sb.axis_pts[i]) > hi) hi = longint'(sb.axis_pts[i]);
    end
    lo = lo * AXIS_SCALE - 1024;
    hi = hi * AXIS_SCALE + 1024;
    r = lo + longint'($urandom_range(0, int'(hi - lo)));
    if (r < RADIUS_MIN) r = RADIUS_MIN;
    if (r > RADIUS_MAX) r = RADIUS_MAX;
    return int'(r);
  endfunction

  task automatic random_request();
    int roll;
    int kind;
    int t;
    int r;
    roll = $urandom_range(0, 99);
    kind = $urandom_range(0, 99);
    if (roll < 8) begin
      case ($urandom_range(0, 2))
        0:       load_entry(CMD_LOAD_AXIS, $urandom_range(0, 15), rand_value());
        1:       load_entry(CMD_LOAD_LEFT, $urandom_range(0, 15), rand_value());
        default: load_entry(CMD_LOAD_RIGHT, $urandom_range(0, 15), rand_value());
      endcase
    end else if (roll < 16) begin
      compute(1'b0, rand_tele(), $urandom());
    end else if (kind < 30) begin
      if ($urandom_range(0, 3) == 0) t = 8192 + int'($urandom_range(0, 80)) - 40;
      else t = rand_tele();
      compute(1'b1, t, $urandom());
    end else begin
      t = 8192 + int'($urandom_range(0, 32)) - 16;
      if (kind >= 92) r = 0;
      else if ($urandom_range(0, 4) == 0) r = $urandom();
      else r = span_radius();
      compute(1'b1, t, r);
    end
  endtask

  initial begin
    int i;
    int phase;
    int k;
    sb = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_cmd <= CMD_COMPUTE;
    in_human_in_loop <= 1'b0;
    in_tele_request <= '0;
    in_av_turn_radius <= '0;
    in_entry_index <= '0;
    in_entry_value <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_FULL_LEFT;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every point before any lookup can read it.
    for (i = 0; i < POINTS; i++) load_entry(CMD_LOAD_AXIS, i, -24000 + 3200 * i);
    for (i = 0; i < POINTS; i++) load_entry(CMD_LOAD_LEFT, i, 5000 - 90 * i);
    for (i = 0; i < POINTS; i++) load_entry(CMD_LOAD_RIGHT, i, 5200 + 110 * i);

    // Directed: value extremes, deadman, gamepad threshold, axis ends and points.
    load_entry(CMD_LOAD_AXIS, 0, -32768);
    load_entry(CMD_LOAD_LEFT, 15, 65535);
    load_entry(CMD_LOAD_RIGHT, 0, -32768);
    compute(1'b0, 16384, 5000);
    compute(1'b1, 16384, 0);
    compute(1'b1, -16384, 0);
    compute(1'b1, 0, 0);
    compute(1'b1, 8192, 0);
    compute(1'b1, 8208, 0);
    compute(1'b1, 8209, 0);
    compute(1'b1, 8175, 0);
    compute(1'b1, 8176, 100);
    compute(1'b1, 8192, RADIUS_MAX);
    compute(1'b1, 8192, RADIUS_MIN);
    compute(1'b1, 8192, (-24000 + 3 * 3200) * 256);
    compute(1'b1, 8192, (-24000 + 10 * 3200) * 256 + 128);
    compute(1'b1, 8192, 1);
    compute(1'b1, 8192, -1);
    compute(1'b1, 8192, 24000 * 256);
    compute(1'b1, 8192, 24000 * 256 - 1);

    for (phase = 0; phase < 6; phase++) begin
      drain(SETTLE_CYCLES);
      case (phase)
        0:       configure(65535, 0, 65535, 1);
        1:       configure(0, 65535, 0, 16);
        2:       configure($urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 65535), 2);
        3:       configure($urandom_range(3000, 4500), $urandom_range(4800, 5400),
                           $urandom_range(6000, 7500), $urandom_range(1, 16));
        4:       configure($urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 65535), $urandom_range(1, 16));
        default: configure(int'(FULL_LEFT_RST), int'(CENTRE_RST), int'(FULL_RIGHT_RST),
                           int'(PTS_RST));
      endcase
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 63; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 63; end
        default: begin gap_pct = 37; stall_pct = 37; end
      endcase
      reload_tables($urandom_range(0, 3) != 0);
      for (k = 0; k < 95; k++) begin
        // hold off until the block has returned everything
        if (phase == 2 && k == 47) drain(0);
        random_request();
      end
    end

    drain(SETTLE_CYCLES);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/sati_pkg.sv
design/sati_ram.sv
design/sati_div.sv
design/steering_arbiter_table_interp.sv
tb/steering_arbiter_table_interp_tb.sv
